// ===== rtl/core/rsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Ring segment allocator package
// Shared widths, default sizes, command modes and result status codes.
// ----------------------------------------------------------------------------
package rsa_pkg;

	localparam int UNIT_BITS         = 16;
	localparam int STATUS_BITS       = 2;
	localparam int MAX_SEGMENTS_DEF  = 16;

	localparam logic MODE_REQUEST = 1'b0;
	localparam logic MODE_RETURN  = 1'b1;

	localparam logic [STATUS_BITS-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_NO_ROOM   = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_LIST_FULL = 2'd2;
	localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd3;

endpackage

// ===== rtl/core/rsa_seg_mem.sv =====
// ----------------------------------------------------------------------------
// Ring segment allocator segment store
// Synchronous memory of segment entries with one write port and one read
// port; read data is registered and appears in the cycle after the read is issued.
// ----------------------------------------------------------------------------
module rsa_seg_mem #(
	parameter int DEPTH  = rsa_pkg::MAX_SEGMENTS_DEF,
	parameter int ADDR_W = $clog2(rsa_pkg::MAX_SEGMENTS_DEF),
	parameter int DATA_W = 2 * rsa_pkg::UNIT_BITS
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/ring_segment_allocator.sv =====
// ----------------------------------------------------------------------------
// Ring segment allocator
// Hands out segments of a backing store and takes them back, keeping the
// borrowed segments as an ordered list in a circular segment memory.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. Mode request
// places a segment of the given length at the list head or after the last
// segment; mode return clears the first segment whose offset is not below
// the given one and trims empty segments from both list ends. Each item
// gives exactly one result, shown for one cycle with result_valid; the
// receiver cannot stall, so the result is simply dropped if not captured.
// Busy falls in the cycle the result is shown, so a new item can be taken
// then. A request reads the head entry and, if the new segment does not
// fit before it, the tail entry. A return scans the entries in order,
// then trims each list end with a read and a check per entry; the single
// read port of the segment memory sets this pace. The user must write the
// capacity register with cfg_wr_en and cfg_wr_data only while the block
// is idle; the block itself does not enforce this. Reset empties the list
// and clears the capacity; no memory clearing is needed.
// ----------------------------------------------------------------------------
module ring_segment_allocator #(
	parameter int MAX_SEGMENTS = rsa_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rsa_pkg::UNIT_BITS-1:0]   cfg_wr_data,
	input  logic                            start,
	output logic                            busy,
	input  logic                            mode,
	input  logic [rsa_pkg::UNIT_BITS-1:0]   length,
	input  logic [rsa_pkg::UNIT_BITS-1:0]   offset,
	output logic                            result_valid,
	output logic [rsa_pkg::STATUS_BITS-1:0] status,
	output logic [rsa_pkg::UNIT_BITS-1:0]   granted_offset
);

	localparam int UB     = rsa_pkg::UNIT_BITS;
	localparam int IDX_W  = $clog2(MAX_SEGMENTS);
	localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
	localparam int DATA_W = 2 * UB;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_REQ_HEAD = 3'd1;
	localparam logic [2:0] S_REQ_TAIL = 3'd2;
	localparam logic [2:0] S_SCAN     = 3'd3;
	localparam logic [2:0] S_TF_RD    = 3'd4;
	localparam logic [2:0] S_TF_CHK   = 3'd5;
	localparam logic [2:0] S_TB_RD    = 3'd6;
	localparam logic [2:0] S_TB_CHK   = 3'd7;

	logic [2:0]        state_q, state_d;
	logic [IDX_W-1:0]  head_q, head_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  pos_q, pos_d;
	logic              chk_valid_q, chk_valid_d;
	logic [IDX_W-1:0]  chk_slot_q, chk_slot_d;
	logic [UB-1:0]     cap_q;
	logic [UB-1:0]     len_q, len_d;
	logic [UB-1:0]     off_q, off_d;
	logic              res_valid_q, res_valid_d;
	logic [rsa_pkg::STATUS_BITS-1:0] res_status_q, res_status_d;
	logic [UB-1:0]     res_granted_q, res_granted_d;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [DATA_W-1:0] rd_data;

	logic [UB-1:0]     rd_start;
	logic [UB-1:0]     rd_len;
	logic [IDX_W-1:0]  head_dec;
	logic [IDX_W-1:0]  head_inc;
	logic [IDX_W-1:0]  tail_slot;
	logic [IDX_W-1:0]  next_slot;
	logic [UB:0]       tail_end;
	logic [UB+1:0]     tail_need;
	logic              tail_fits;
	logic              scan_hit;

	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] pos);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(pos);
		if (sum >= (CNT_W+1)'(MAX_SEGMENTS)) begin
			sum = sum - (CNT_W+1)'(MAX_SEGMENTS);
		end
		return sum[IDX_W-1:0];
	endfunction

	rsa_seg_mem #(
		.DEPTH  (MAX_SEGMENTS),
		.ADDR_W (IDX_W),
		.DATA_W (DATA_W)
	) u_seg_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_start  = rd_data[DATA_W-1:UB];
	assign rd_len    = rd_data[UB-1:0];
	assign head_dec  = (head_q == '0) ? IDX_W'(MAX_SEGMENTS - 1) : head_q - IDX_W'(1);
	assign head_inc  = (head_q == IDX_W'(MAX_SEGMENTS - 1)) ? '0 : head_q + IDX_W'(1);
	assign tail_slot = slot_of(head_q, count_q - CNT_W'(1));
	assign next_slot = slot_of(head_q, count_q);
	assign tail_end  = {1'b0, rd_start} + {1'b0, rd_len};
	assign tail_need = {1'b0, tail_end} + {2'b00, len_q};
	assign tail_fits = tail_need <= {2'b00, cap_q};
	assign scan_hit  = chk_valid_q && (rd_start >= off_q);

	assign busy           = (state_q != S_IDLE);
	assign result_valid   = res_valid_q;
	assign status         = res_status_q;
	assign granted_offset = res_granted_q;

	always_comb begin
		state_d       = state_q;
		head_d        = head_q;
		count_d       = count_q;
		pos_d         = pos_q;
		chk_valid_d   = chk_valid_q;
		chk_slot_d    = chk_slot_q;
		len_d         = len_q;
		off_d         = off_q;
		res_valid_d   = 1'b0;
		res_status_d  = res_status_q;
		res_granted_d = res_granted_q;
		wr_en         = 1'b0;
		wr_addr       = '0;
		wr_data       = '0;
		rd_en         = 1'b0;
		rd_addr       = '0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					len_d         = length;
					off_d         = offset;
					res_granted_d = '0;
					res_status_d  = rsa_pkg::ST_DONE;
					if (mode == rsa_pkg::MODE_REQUEST) begin
						if (count_q == CNT_W'(MAX_SEGMENTS)) begin
							res_valid_d  = 1'b1;
							res_status_d = rsa_pkg::ST_LIST_FULL;
						end else if (count_q == '0) begin
							res_valid_d = 1'b1;
							if (length == '0) begin
								wr_en   = 1'b1;
								wr_addr = head_dec;
								wr_data = '0;
								head_d  = head_dec;
								count_d = count_q + CNT_W'(1);
							end else if (length <= cap_q) begin
								wr_en   = 1'b1;
								wr_addr = head_q;
								wr_data = {UB'(0), length};
								count_d = count_q + CNT_W'(1);
							end else begin
								res_status_d = rsa_pkg::ST_NO_ROOM;
							end
						end else begin
							rd_en   = 1'b1;
							rd_addr = head_q;
							state_d = S_REQ_HEAD;
						end
					end else begin
						if (count_q == '0) begin
							res_valid_d  = 1'b1;
							res_status_d = rsa_pkg::ST_NOT_FOUND;
						end else begin
							pos_d       = '0;
							chk_valid_d = 1'b0;
							state_d     = S_SCAN;
						end
					end
				end
			end
			S_REQ_HEAD: begin
				if (len_q <= rd_start) begin
					wr_en         = 1'b1;
					wr_addr       = head_dec;
					wr_data       = {rd_start - len_q, len_q};
					head_d        = head_dec;
					count_d       = count_q + CNT_W'(1);
					res_valid_d   = 1'b1;
					res_granted_d = rd_start - len_q;
					state_d       = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = tail_slot;
					state_d = S_REQ_TAIL;
				end
			end
			S_REQ_TAIL: begin
				res_valid_d = 1'b1;
				state_d     = S_IDLE;
				if (tail_fits) begin
					wr_en         = 1'b1;
					wr_addr       = next_slot;
					wr_data       = {tail_end[UB-1:0], len_q};
					count_d       = count_q + CNT_W'(1);
					res_granted_d = tail_end[UB-1:0];
				end else begin
					res_status_d = rsa_pkg::ST_NO_ROOM;
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					wr_en   = 1'b1;
					wr_addr = chk_slot_q;
					wr_data = {rd_start, UB'(0)};
					state_d = S_TF_RD;
				end else if (pos_q == count_q) begin
					res_valid_d  = 1'b1;
					res_status_d = rsa_pkg::ST_NOT_FOUND;
					state_d      = S_IDLE;
				end else begin
					rd_en       = 1'b1;
					rd_addr     = slot_of(head_q, pos_q);
					chk_slot_d  = slot_of(head_q, pos_q);
					chk_valid_d = 1'b1;
					pos_d       = pos_q + CNT_W'(1);
				end
			end
			S_TF_RD: begin
				if (count_q == '0) begin
					head_d      = '0;
					res_valid_d = 1'b1;
					state_d     = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = head_q;
					state_d = S_TF_CHK;
				end
			end
			S_TF_CHK: begin
				if (rd_len == '0) begin
					head_d  = head_inc;
					count_d = count_q - CNT_W'(1);
					state_d = S_TF_RD;
				end else begin
					state_d = S_TB_RD;
				end
			end
			S_TB_RD: begin
				if (count_q == '0) begin
					head_d      = '0;
					res_valid_d = 1'b1;
					state_d     = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = tail_slot;
					state_d = S_TB_CHK;
				end
			end
			S_TB_CHK: begin
				if (rd_len == '0) begin
					count_d = count_q - CNT_W'(1);
					state_d = S_TB_RD;
				end else begin
					res_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			chk_valid_q <= 1'b0;
			cap_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			count_q     <= count_d;
			pos_q       <= pos_d;
			chk_valid_q <= chk_valid_d;
			res_valid_q <= res_valid_d;
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_slot_q    <= chk_slot_d;
		len_q         <= len_d;
		off_q         <= off_d;
		res_status_q  <= res_status_d;
		res_granted_q <= res_granted_d;
	end

endmodule
